FILE: design/mlpq_pkg.sv
package mlpq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int TIME_BITS   = 16;
   localparam int LEVELS      = 4;

   localparam int LEVEL_BITS  = 2;
   localparam int ID_BITS     = 4;
   localparam int PTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_BITS   = LEVEL_BITS + PTR_BITS;
   localparam int MEM_DEPTH   = LEVELS * QUEUE_DEPTH;

   typedef logic [1:0] opcode_type;
   localparam opcode_type OP_ENQUEUE      = 2'd0;
   localparam opcode_type OP_SELECT       = 2'd1;
   localparam opcode_type OP_TAKE_HIGHEST = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type ST_ENQUEUED = 2'd0;
   localparam status_type ST_SELECTED = 2'd1;
   localparam status_type ST_EMPTY    = 2'd2;
   localparam status_type ST_FULL     = 2'd3;

   typedef logic [LEVEL_BITS-1:0] level_type;
   localparam level_type LVL_LONGEST  = 2'd0;
   localparam level_type LVL_SHORTEST = 2'd3;

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [TIME_BITS-1:0] rtime;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       decode;
      logic       enq;
      logic       scan_step;
      logic       shift_start;
      logic       shift_step;
      logic       remove;
      logic       respond;
      status_type status;
   } cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       empty;
      logic       full;
      logic       scan_done;
      logic       shift_done;
      logic       rsp_free;
   } sts_type;

endpackage

FILE: design/mlpq_ctrl.sv
module mlpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mlpq_pkg::sts_type sts,
   output mlpq_pkg::cmd_type cmd
);
   import mlpq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   status_type result_ff, result_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      result_in = result_ff;
      cmd       = '0;
      cmd.status = result_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            priority if (sts.op == OP_ENQUEUE) begin
               if (sts.full) begin
                  result_in = ST_FULL;
               end else begin
                  cmd.enq   = 1'b1;
                  result_in = ST_ENQUEUED;
               end
               state_in = S_FINISH;
            end else if (sts.op == OP_SELECT || sts.op == OP_TAKE_HIGHEST) begin
               if (sts.empty) begin
                  result_in = ST_EMPTY;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               result_in = ST_EMPTY;
               state_in  = S_FINISH;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               cmd.shift_start = 1'b1;
               state_in        = S_SHIFT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SHIFT: begin
            if (sts.shift_done) begin
               cmd.remove = 1'b1;
               result_in  = ST_SELECTED;
               state_in   = S_FINISH;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         result_ff <= ST_EMPTY;
      end else begin
         state_ff  <= state_in;
         result_ff <= result_in;
      end
   end

   a_respond_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> sts.rsp_free)
      else $error("response issued while output register busy");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !cmd.load)
      else $error("item loaded outside idle");

   a_selected_via_shift: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && $past(state_ff) != S_FINISH && result_ff == ST_SELECTED)
      |-> $past(state_ff) == S_SHIFT)
      else $error("selected result without removal pass");

endmodule

FILE: design/mlpq_datapath.sv
module mlpq_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [1:0]                      req_opcode,
   input  logic [1:0]                      req_level,
   input  logic [3:0]                      req_task_id,
   input  logic [15:0]                     req_remaining_time,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [3:0]                      rsp_chosen_task,
   output logic [1:0]                      rsp_chosen_level,
   input  mlpq_pkg::cmd_type               cmd,
   output mlpq_pkg::sts_type               sts
);
   import mlpq_pkg::*;

   entry_type mem [MEM_DEPTH];

   opcode_type            op_ff;
   level_type             lv_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [TIME_BITS-1:0]  tm_ff;

   logic [CNT_BITS-1:0]   cnt_ff [LEVELS];
   logic [CNT_BITS-1:0]   cnt_in [LEVELS];

   level_type             eff_lv_ff;
   logic [CNT_BITS-1:0]   len_ff;
   logic [CNT_BITS-1:0]   iss_ff, iss_in;
   logic [CNT_BITS-1:0]   sh_ff, sh_in;

   logic                  rd_valid_ff, rd_valid_in;
   logic                  rd_shift_ff, rd_shift_in;
   logic [PTR_BITS-1:0]   rd_idx_ff, rd_idx_in;
   entry_type             rd_data_ff;

   logic [PTR_BITS-1:0]   best_pos_ff;
   logic [TIME_BITS-1:0]  best_time_ff;
   logic [ID_BITS-1:0]    best_id_ff;

   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [ID_BITS-1:0]    rsp_task_ff;
   level_type             rsp_level_ff;

   level_type             high_lv;
   logic                  any_busy;
   level_type             sel_lv;
   logic                  scan_policy;
   logic [CNT_BITS-1:0]   cur_cnt;

   logic                  rd_en;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   entry_type             wr_data;
   logic                  better;

   // highest non-empty level, later index wins
   always_comb begin
      high_lv  = '0;
      any_busy = 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
         if (cnt_ff[l] != '0) begin
            high_lv  = level_type'(l);
            any_busy = 1'b1;
         end
      end
   end

   assign sel_lv      = (op_ff == OP_TAKE_HIGHEST) ? high_lv : lv_ff;
   assign scan_policy = (op_ff == OP_SELECT) &&
                        (lv_ff == LVL_LONGEST || lv_ff == LVL_SHORTEST);
   assign cur_cnt     = cnt_ff[eff_lv_ff];

   assign sts.op         = op_ff;
   assign sts.empty      = (op_ff == OP_TAKE_HIGHEST) ? !any_busy : (cnt_ff[lv_ff] == '0);
   assign sts.full       = (cnt_ff[lv_ff] >= CNT_BITS'(QUEUE_DEPTH));
   assign sts.scan_done  = (iss_ff >= len_ff) && !rd_valid_ff;
   assign sts.shift_done = (sh_ff >= cur_cnt) && !rd_valid_ff;
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

   // read issue: scan walks from the front, shift reads the entry after the gap
   always_comb begin
      rd_en       = 1'b0;
      rd_addr     = {eff_lv_ff, iss_ff[PTR_BITS-1:0]};
      rd_idx_in   = iss_ff[PTR_BITS-1:0];
      rd_shift_in = 1'b0;
      iss_in      = iss_ff;
      sh_in       = sh_ff;
      if (cmd.decode) begin
         iss_in = '0;
      end else if (cmd.scan_step && iss_ff < len_ff) begin
         rd_en  = 1'b1;
         iss_in = iss_ff + 1'b1;
      end
      if (cmd.shift_start) begin
         sh_in = CNT_BITS'(best_pos_ff) + 1'b1;
      end else if (cmd.shift_step && sh_ff < cur_cnt) begin
         rd_en       = 1'b1;
         rd_addr     = {eff_lv_ff, sh_ff[PTR_BITS-1:0]};
         rd_idx_in   = sh_ff[PTR_BITS-1:0];
         rd_shift_in = 1'b1;
         sh_in       = sh_ff + 1'b1;
      end
      rd_valid_in = rd_en;
   end

   // write: append on enqueue, or move a read-back entry one place forward
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {lv_ff, cnt_ff[lv_ff][PTR_BITS-1:0]};
      wr_data = '{id: id_ff, rtime: tm_ff};
      if (cmd.enq) begin
         wr_en = 1'b1;
      end else if (rd_valid_ff && rd_shift_ff) begin
         wr_en   = 1'b1;
         wr_addr = {eff_lv_ff, rd_idx_ff - 1'b1};
         wr_data = rd_data_ff;
      end
   end

   always_comb begin
      better = (rd_idx_ff == '0);
      if (eff_lv_ff == LVL_SHORTEST && rd_data_ff.rtime < best_time_ff) begin
         better = 1'b1;
      end
      if (eff_lv_ff == LVL_LONGEST && rd_data_ff.rtime > best_time_ff) begin
         better = 1'b1;
      end
   end

   always_comb begin
      for (int l = 0; l < LEVELS; l++) begin
         cnt_in[l] = cnt_ff[l];
      end
      if (cmd.enq) begin
         cnt_in[lv_ff] = cnt_ff[lv_ff] + 1'b1;
      end else if (cmd.remove) begin
         cnt_in[eff_lv_ff] = cnt_ff[eff_lv_ff] - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_opcode;
         lv_ff <= req_level;
         id_ff <= req_task_id;
         tm_ff <= TIME_BITS'(req_remaining_time);
      end
      if (cmd.decode) begin
         eff_lv_ff <= sel_lv;
         len_ff    <= scan_policy ? cnt_ff[sel_lv] : CNT_BITS'(1);
      end
      if (rd_valid_ff && !rd_shift_ff && better) begin
         best_pos_ff  <= rd_idx_ff;
         best_time_ff <= rd_data_ff.rtime;
         best_id_ff   <= rd_data_ff.id;
      end
      iss_ff      <= iss_in;
      sh_ff       <= sh_in;
      rd_idx_ff   <= rd_idx_in;
      rd_shift_ff <= rd_shift_in;
      if (cmd.respond) begin
         rsp_status_ff <= cmd.status;
         rsp_task_ff   <= (cmd.status == ST_SELECTED) ? best_id_ff : '0;
         rsp_level_ff  <= (cmd.status == ST_SELECTED) ? eff_lv_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LEVELS; l++) begin
            cnt_ff[l] <= '0;
         end
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff      <= cnt_in;
         rd_valid_ff <= rd_valid_in;
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_task  = rsp_task_ff;
   assign rsp_chosen_level = rsp_level_ff;

   for (genvar g = 0; g < LEVELS; g++) begin : g_cnt_chk
      a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
         cnt_ff[g] <= CNT_BITS'(QUEUE_DEPTH))
         else $error("queue count above depth");
   end

   a_shift_target: assert property (@(posedge clock) disable iff (reset)
      (rd_valid_ff && rd_shift_ff) |-> (rd_idx_ff != '0))
      else $error("shift would write before the queue front");

   a_zero_when_not_selected: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_SELECTED) |->
      (rsp_task_ff == '0 && rsp_level_ff == '0))
      else $error("chosen fields nonzero without selection");

   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(cmd.enq && rd_valid_ff && rd_shift_ff))
      else $error("append collides with shift write");

endmodule

FILE: design/multilevel_policy_ready_queue.sv
// Four ready queues (level 3 highest) of task id and remaining time, one item at a time.
// An enqueue, a full drop, an empty result or an unused opcode goes from accept through
// decode straight to finish. A select scans the level through the entry memory's
// single registered read port, then closes the gap by reading and rewriting each later
// entry: levels 0 and 3 are scanned whole for the longest or shortest remaining time,
// levels 1 and 2 and take-highest only at the front. The next item is accepted once the
// result is in the output register, while it still waits to be taken. Entries need no
// clearing after reset; per-level fill counts start at zero.
module multilevel_policy_ready_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [1:0]  req_level,
   input  logic [3:0]  req_task_id,
   input  logic [15:0] req_remaining_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_chosen_task,
   output logic [1:0]  rsp_chosen_level
);
   import mlpq_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mlpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   mlpq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_opcode         (req_opcode),
      .req_level          (req_level),
      .req_task_id        (req_task_id),
      .req_remaining_time (req_remaining_time),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_chosen_task    (rsp_chosen_task),
      .rsp_chosen_level   (rsp_chosen_level),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule
